FILE: design/kvi_pkg.sv
// Package of the keyframe voxel interpolator: widths, register codes and the
// records that travel down the pipeline. No dependencies.
package kvi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int MAX_KEYS  = 64;
   localparam int KEY_W     = 6;
   localparam int CNT_W     = 7;
   localparam int FRAC_W    = 17;
   localparam int DATA_W    = 16;

   localparam logic [FRAC_W-1:0] ONE_Q      = 17'h10000;
   localparam logic [DATA_W-1:0] MID_CODE   = 16'h8000;
   localparam logic [32:0]       SCALAR_RND = 33'h8000;
   localparam logic [32:0]       NORMAL_RND = 33'h80;
   localparam logic [23:0]       CENTER     = 24'h800000;

   // Lerped normal component magnitude and the square-root and divider sizes.
   localparam int MAG_W      = 24;
   localparam int SQ_W       = 47;
   localparam int SUM_W      = 48;
   localparam int SQ_RAD_W   = 62;
   localparam int SQ_ROOT_W  = 31;
   localparam int SQ_REM_W   = 33;
   localparam int DV_DVD_W   = 47;
   localparam int DV_DVS_W   = 32;
   localparam int DV_QUO_W   = 18;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REG_BLEND_FRACTION = 1'b0,
      REG_KEY_COUNT      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0]         blended_scalar;
      logic [2:0][DATA_W-1:0]    normal_a;
      logic [2:0][MAG_W-1:0]     mag;
      logic [2:0]                neg;
      logic                      pass;
      logic                      zero;
      logic [KEY_W-1:0]          lower_key;
      logic [KEY_W-1:0]          upper_key;
      logic                      last;
   } side_type;

   typedef struct packed {
      logic [DATA_W-1:0] blended_scalar;
      logic [DATA_W-1:0] blended_normal_x;
      logic [DATA_W-1:0] blended_normal_y;
      logic [DATA_W-1:0] blended_normal_z;
      logic [KEY_W-1:0]  lower_key;
      logic [KEY_W-1:0]  upper_key;
      logic              last_voxel_out;
   } rsp_type;

endpackage

FILE: design/kvi_if.sv
// Valid/ready channels of the keyframe voxel interpolator: voxel pair in,
// blended voxel out. Depends on kvi_pkg.
interface kvi_req_if;
   logic                       valid;
   logic                       ready;
   logic [kvi_pkg::DATA_W-1:0] scalar_a;
   logic [kvi_pkg::DATA_W-1:0] normal_a_x;
   logic [kvi_pkg::DATA_W-1:0] normal_a_y;
   logic [kvi_pkg::DATA_W-1:0] normal_a_z;
   logic [kvi_pkg::DATA_W-1:0] scalar_b;
   logic [kvi_pkg::DATA_W-1:0] normal_b_x;
   logic [kvi_pkg::DATA_W-1:0] normal_b_y;
   logic [kvi_pkg::DATA_W-1:0] normal_b_z;
   logic                       last_voxel_in;

   modport source (output valid, scalar_a, normal_a_x, normal_a_y, normal_a_z, scalar_b,
                   normal_b_x, normal_b_y, normal_b_z, last_voxel_in, input ready);
   modport sink (input valid, scalar_a, normal_a_x, normal_a_y, normal_a_z, scalar_b,
                 normal_b_x, normal_b_y, normal_b_z, last_voxel_in, output ready);
endinterface

interface kvi_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [kvi_pkg::DATA_W-1:0] blended_scalar;
   logic [kvi_pkg::DATA_W-1:0] blended_normal_x;
   logic [kvi_pkg::DATA_W-1:0] blended_normal_y;
   logic [kvi_pkg::DATA_W-1:0] blended_normal_z;
   logic [kvi_pkg::KEY_W-1:0]  lower_key;
   logic [kvi_pkg::KEY_W-1:0]  upper_key;
   logic                       last_voxel_out;

   modport source (output valid, blended_scalar, blended_normal_x, blended_normal_y,
                   blended_normal_z, lower_key, upper_key, last_voxel_out, input ready);
   modport sink (input valid, blended_scalar, blended_normal_x, blended_normal_y,
                 blended_normal_z, lower_key, upper_key, last_voxel_out, output ready);
endinterface

FILE: design/kvi_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on kvi_pkg for its widths.
module kvi_sqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [kvi_pkg::SQ_RAD_W-1:0]  radicand,
   output logic [kvi_pkg::SQ_ROOT_W-1:0] root
);
   localparam int RW = kvi_pkg::SQ_RAD_W;
   localparam int OW = kvi_pkg::SQ_ROOT_W;
   localparam int MW = kvi_pkg::SQ_REM_W;

   logic [MW-1:0] rem_ff  [OW];
   logic [OW-1:0] root_ff [OW];
   logic [RW-1:0] x_ff    [OW];

   for (genvar s = 0; s < OW; s++) begin : g_step
      logic [MW-1:0] rem_p;
      logic [OW-1:0] root_p;
      logic [RW-1:0] x_p;
      logic [MW+1:0] rem4;
      logic [MW+1:0] trial;
      logic [MW+1:0] diff;
      logic          fits;
      logic [MW-1:0] rem_in;
      logic [OW-1:0] root_in;
      logic [RW-1:0] x_in;

      if (s == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign x_p    = radicand;
      end else begin : g_next
         assign rem_p  = rem_ff[s-1];
         assign root_p = root_ff[s-1];
         assign x_p    = x_ff[s-1];
      end

      // Bring down the next two radicand bits and try the digit one.
      assign rem4    = {rem_p, x_p[RW-1 -: 2]};
      assign trial   = {2'b00, root_p, 2'b01};
      assign fits    = rem4 >= trial;
      assign diff    = rem4 - trial;
      assign rem_in  = fits ? diff[MW-1:0] : rem4[MW-1:0];
      assign root_in = {root_p[OW-2:0], fits};
      assign x_in    = {x_p[RW-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            x_ff[s]    <= x_in;
         end
      end
   end

   assign root = root_ff[OW-1];

endmodule

FILE: design/kvi_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on kvi_pkg; the quotient must fit in DV_QUO_W bits.
module kvi_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [kvi_pkg::DV_DVD_W-1:0] dividend,
   input  logic [kvi_pkg::DV_DVS_W-1:0] divisor,
   output logic [kvi_pkg::DV_QUO_W-1:0] quotient
);
   localparam int NW = kvi_pkg::DV_DVD_W;
   localparam int DW = kvi_pkg::DV_DVS_W;
   localparam int QW = kvi_pkg::DV_QUO_W;
   localparam int CW = DW + QW;

   logic [NW-1:0] rem_ff [QW];
   logic [DW-1:0] d_ff   [QW];
   logic [QW-1:0] q_ff   [QW];

   for (genvar s = 0; s < QW; s++) begin : g_step
      logic [NW-1:0] rem_p;
      logic [DW-1:0] d_p;
      logic [QW-1:0] q_p;
      logic [CW-1:0] rem_e;
      logic [CW-1:0] sh;
      logic [CW-1:0] diff;
      logic          fits;

      if (s == 0) begin : g_first
         assign rem_p = dividend;
         assign d_p   = divisor;
         assign q_p   = '0;
      end else begin : g_next
         assign rem_p = rem_ff[s-1];
         assign d_p   = d_ff[s-1];
         assign q_p   = q_ff[s-1];
      end

      // Stage s decides quotient bit QW-1-s.
      assign rem_e = {{(CW-NW){1'b0}}, rem_p};
      assign sh    = {{QW{1'b0}}, d_p} << (QW - 1 - s);
      assign fits  = rem_e >= sh;
      assign diff  = rem_e - sh;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= fits ? diff[NW-1:0] : rem_p;
            d_ff[s]   <= d_p;
            q_ff[s]   <= {q_p[QW-2:0], fits};
         end
      end
   end

   assign quotient = q_ff[QW-1];

endmodule

FILE: design/keyframe_voxel_interpolator_top.sv
// Keyframe voxel interpolator: key selection, lerp, renormalization of the
// normal and output buffering. Depends on kvi_pkg, kvi_if, kvi_sqrt, kvi_div.
//
//   port       direction  contents
//   req_bus    in         voxel pair from the lower and upper key volumes
//   rsp_bus    out        blended scalar and normal, key indices, last marker
//   csr_*      in/out     blend_fraction at 0x0, key_count at 0x4
//
// One item enters every cycle while req_bus.ready is high. An item passes 56
// register stages; the 31-stage square root and the 18-stage divider make up
// most of them.
// Reset clears the valid bits and sets blend_fraction to 0 and key_count to 1.
// A held result parks in the output register and one more in a skid register;
// req_bus.ready drops only while the skid register is full.
module keyframe_voxel_interpolator_top (
   input  logic                              clock,
   input  logic                              reset,
   kvi_req_if.sink                           req_bus,
   kvi_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [kvi_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [kvi_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [kvi_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   localparam int SQN = kvi_pkg::SQ_ROOT_W;
   localparam int DVN = kvi_pkg::DV_QUO_W;
   localparam int DW  = kvi_pkg::DATA_W;
   localparam int KW  = kvi_pkg::KEY_W;

   // ---------------- configuration registers ----------------
   logic [kvi_pkg::FRAC_W-1:0] blend_fraction_ff;
   logic [kvi_pkg::CNT_W-1:0]  key_count_ff;
   logic                       csr_write;
   kvi_pkg::csr_index_type     csr_sel;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = kvi_pkg::csr_index_type'(csr_paddr[kvi_pkg::CSR_ADDR_W-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_fraction_ff <= '0;
         key_count_ff      <= kvi_pkg::CNT_W'(1);
      end else if (csr_write) begin
         case (csr_sel)
            kvi_pkg::REG_BLEND_FRACTION: blend_fraction_ff <= csr_pwdata[kvi_pkg::FRAC_W-1:0];
            kvi_pkg::REG_KEY_COUNT:      key_count_ff <= csr_pwdata[kvi_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         kvi_pkg::REG_BLEND_FRACTION:
            csr_prdata = {{(kvi_pkg::CSR_DATA_W-kvi_pkg::FRAC_W){1'b0}}, blend_fraction_ff};
         kvi_pkg::REG_KEY_COUNT:
            csr_prdata = {{(kvi_pkg::CSR_DATA_W-kvi_pkg::CNT_W){1'b0}}, key_count_ff};
         default: csr_prdata = '0;
      endcase
   end

   // ---------------- key pair and weight ----------------
   logic [kvi_pkg::CNT_W-1:0] cnt;
   logic [KW-1:0]             limit;
   logic [21:0]               t_prod;
   logic [KW-1:0]             sel_lo;
   logic [KW-1:0]             sel_hi;
   logic [DW-1:0]             sel_w;

   always_comb begin
      if (key_count_ff == '0) begin
         cnt = kvi_pkg::CNT_W'(1);
      end else if (key_count_ff > kvi_pkg::CNT_W'(kvi_pkg::MAX_KEYS)) begin
         cnt = kvi_pkg::CNT_W'(kvi_pkg::MAX_KEYS);
      end else begin
         cnt = key_count_ff;
      end
      limit  = KW'(cnt - kvi_pkg::CNT_W'(1));
      t_prod = {6'b0, blend_fraction_ff[DW-1:0]} * {16'b0, limit};
      if (blend_fraction_ff == '0) begin
         sel_lo = '0;
         sel_hi = '0;
         sel_w  = '0;
      end else if (blend_fraction_ff[kvi_pkg::FRAC_W-1]) begin
         sel_lo = limit;
         sel_hi = limit;
         sel_w  = '0;
      end else begin
         sel_lo = t_prod[21:16];
         sel_w  = t_prod[15:0];
         sel_hi = (sel_lo < limit) ? sel_lo + KW'(1) : sel_lo;
      end
   end

   // ---------------- pipeline control ----------------
   logic adv;
   logic skid_valid_ff;

   assign adv           = !skid_valid_ff;
   assign req_bus.ready = adv;

   // Stage 1: capture the item with its key pair and weight.
   logic               v1_ff;
   logic [DW-1:0]      s1_sa_ff, s1_sb_ff, s1_w_ff;
   logic [2:0][DW-1:0] s1_na_ff, s1_nb_ff;
   logic [KW-1:0]      s1_lo_ff, s1_hi_ff;
   logic               s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sa_ff   <= req_bus.scalar_a;
         s1_sb_ff   <= req_bus.scalar_b;
         s1_na_ff   <= {req_bus.normal_a_z, req_bus.normal_a_y, req_bus.normal_a_x};
         s1_nb_ff   <= {req_bus.normal_b_z, req_bus.normal_b_y, req_bus.normal_b_x};
         s1_w_ff    <= sel_w;
         s1_lo_ff   <= sel_lo;
         s1_hi_ff   <= sel_hi;
         s1_last_ff <= req_bus.last_voxel_in;
      end
   end

   // Stage 2: weighted sums a*(1-w) + b*w.
   logic [32:0]          omw_e, w_e;
   logic [32:0]          ls_in;
   logic [2:0][32:0]     ln_in;
   kvi_pkg::side_type    side2_in;
   logic                 v2_ff;
   logic [32:0]          s2_ls_ff;
   logic [2:0][32:0]     s2_ln_ff;
   kvi_pkg::side_type    s2_side_ff;

   always_comb begin
      omw_e = {16'b0, kvi_pkg::ONE_Q - {1'b0, s1_w_ff}};
      w_e   = {17'b0, s1_w_ff};
      ls_in = {17'b0, s1_sa_ff} * omw_e + {17'b0, s1_sb_ff} * w_e;
      for (int i = 0; i < 3; i++) begin
         ln_in[i] = {17'b0, s1_na_ff[i]} * omw_e + {17'b0, s1_nb_ff[i]} * w_e;
      end
      side2_in           = '0;
      side2_in.normal_a  = s1_na_ff;
      side2_in.pass      = (s1_w_ff == '0);
      side2_in.lower_key = s1_lo_ff;
      side2_in.upper_key = s1_hi_ff;
      side2_in.last      = s1_last_ff;
      side2_in.blended_scalar = s1_sa_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ls_ff   <= ls_in;
         s2_ln_ff   <= ln_in;
         s2_side_ff <= side2_in;
      end
   end

   // Stage 3: round, then center each normal component on midscale.
   kvi_pkg::side_type side3_in;
   logic [32:0]       sc_rnd;
   logic [2:0][32:0]  ln_rnd;
   logic              v3_ff;
   kvi_pkg::side_type s3_side_ff;

   always_comb begin
      side3_in = s2_side_ff;
      sc_rnd   = s2_ls_ff + kvi_pkg::SCALAR_RND;
      if (!s2_side_ff.pass) begin
         side3_in.blended_scalar = sc_rnd[31:16];
      end
      for (int i = 0; i < 3; i++) begin
         ln_rnd[i]        = s2_ln_ff[i] + kvi_pkg::NORMAL_RND;
         side3_in.neg[i]  = ln_rnd[i][31:8] < kvi_pkg::CENTER;
         side3_in.mag[i]  = side3_in.neg[i] ? kvi_pkg::CENTER - ln_rnd[i][31:8]
                                            : ln_rnd[i][31:8] - kvi_pkg::CENTER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_side_ff <= side3_in;
      end
   end

   // Stage 4: squares of the magnitudes.
   logic [2:0][47:0]            mag_e;
   logic [2:0][47:0]            sqr;
   logic                        v4_ff;
   logic [2:0][kvi_pkg::SQ_W-1:0] s4_sq_ff;
   kvi_pkg::side_type           s4_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_e[i] = {24'b0, s3_side_ff.mag[i]};
         sqr[i]   = mag_e[i] * mag_e[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s4_sq_ff[i] <= sqr[i][kvi_pkg::SQ_W-1:0];
         end
         s4_side_ff <= s3_side_ff;
      end
   end

   // Stage 5: squared length, scaled for the square root.
   logic [kvi_pkg::SUM_W-1:0]    ssum;
   kvi_pkg::side_type            side5_in;
   logic                         v5_ff;
   logic [kvi_pkg::SQ_RAD_W-1:0] s5_x_ff;
   kvi_pkg::side_type            s5_side_ff;

   always_comb begin
      ssum = {1'b0, s4_sq_ff[0]} + {1'b0, s4_sq_ff[1]} + {1'b0, s4_sq_ff[2]};
      side5_in      = s4_side_ff;
      side5_in.zero = (ssum == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_x_ff    <= {ssum, 14'b0};
         s5_side_ff <= side5_in;
      end
   end

   // Square root with its matching delay line.
   logic [SQN-1:0]    len;
   logic              sqv_ff   [SQN];
   kvi_pkg::side_type sqside_ff[SQN];

   kvi_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (s5_x_ff),
      .root     (len)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SQN; j++) begin
            sqv_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         sqv_ff[0] <= v5_ff;
         for (int j = 1; j < SQN; j++) begin
            sqv_ff[j] <= sqv_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqside_ff[0] <= s5_side_ff;
         for (int j = 1; j < SQN; j++) begin
            sqside_ff[j] <= sqside_ff[j-1];
         end
      end
   end

   // Stage 6: operands of m = (|v| * 2^23 + len) / (2 * len).
   logic                              v6_ff;
   logic [2:0][kvi_pkg::DV_DVD_W-1:0] s6_dvd_ff;
   logic [kvi_pkg::DV_DVS_W-1:0]      s6_dvs_ff;
   kvi_pkg::side_type                 s6_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= sqv_ff[SQN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s6_dvd_ff[i] <= {sqside_ff[SQN-1].mag[i], 23'b0} + {16'b0, len};
         end
         s6_dvs_ff  <= {len, 1'b0};
         s6_side_ff <= sqside_ff[SQN-1];
      end
   end

   // Three dividers, one per normal component.
   logic [2:0][DVN-1:0] quo;
   logic              dvv_ff   [DVN];
   kvi_pkg::side_type dvside_ff[DVN];

   for (genvar i = 0; i < 3; i++) begin : g_div
      kvi_div u_div (
         .clock    (clock),
         .en       (adv),
         .dividend (s6_dvd_ff[i]),
         .divisor  (s6_dvs_ff),
         .quotient (quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DVN; j++) begin
            dvv_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         dvv_ff[0] <= v6_ff;
         for (int j = 1; j < DVN; j++) begin
            dvv_ff[j] <= dvv_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dvside_ff[0] <= s6_side_ff;
         for (int j = 1; j < DVN; j++) begin
            dvside_ff[j] <= dvside_ff[j-1];
         end
      end
   end

   // Re-encode around midscale with saturation.
   kvi_pkg::side_type end_side;
   logic              end_valid;
   logic [2:0][DW-1:0] enc;
   logic [DVN:0]      pos_sum;
   kvi_pkg::rsp_type  end_rsp;

   assign end_side  = dvside_ff[DVN-1];
   assign end_valid = dvv_ff[DVN-1];

   always_comb begin
      pos_sum = '0;
      for (int i = 0; i < 3; i++) begin
         if (end_side.pass) begin
            enc[i] = end_side.normal_a[i];
         end else if (end_side.zero) begin
            enc[i] = kvi_pkg::MID_CODE;
         end else if (!end_side.neg[i]) begin
            pos_sum = {1'b0, quo[i]} + (DVN + 1)'(kvi_pkg::MID_CODE);
            enc[i]  = (pos_sum > (DVN + 1)'(16'hFFFF)) ? 16'hFFFF : pos_sum[DW-1:0];
         end else begin
            enc[i] = (quo[i] >= DVN'(kvi_pkg::MID_CODE)) ? '0
                     : kvi_pkg::MID_CODE - quo[i][DW-1:0];
         end
      end
      end_rsp.blended_scalar   = end_side.blended_scalar;
      end_rsp.blended_normal_x = enc[0];
      end_rsp.blended_normal_y = enc[1];
      end_rsp.blended_normal_z = enc[2];
      end_rsp.lower_key        = end_side.lower_key;
      end_rsp.upper_key        = end_side.upper_key;
      end_rsp.last_voxel_out   = end_side.last;
   end

   // ---------------- output register and skid ----------------
   logic             out_valid_ff;
   kvi_pkg::rsp_type out_ff;
   kvi_pkg::rsp_type skid_ff;
   logic             out_free;

   assign out_free = !out_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= end_valid;
         end
      end else if (adv && end_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : end_rsp;
      end else if (adv) begin
         skid_ff <= end_rsp;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.blended_scalar   = out_ff.blended_scalar;
   assign rsp_bus.blended_normal_x = out_ff.blended_normal_x;
   assign rsp_bus.blended_normal_y = out_ff.blended_normal_y;
   assign rsp_bus.blended_normal_z = out_ff.blended_normal_z;
   assign rsp_bus.lower_key        = out_ff.lower_key;
   assign rsp_bus.upper_key        = out_ff.upper_key;
   assign rsp_bus.last_voxel_out   = out_ff.last_voxel_out;

   // ---------------- assertions ----------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds an item while the output register is empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready && adv && end_valid) |=> skid_valid_ff)
      else $error("item leaving the pipeline during a stall was not parked");

   a_key_order: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.lower_key <= out_ff.upper_key))
      else $error("lower key above upper key");

endmodule

FILE: sim/keyframe_voxel_interpolator_top_test.sv
// Self-checking testbench of keyframe_voxel_interpolator_top: random voxel pairs under
// several blend settings, checked against an in-bench blend predictor.
// Depends on kvi_pkg, kvi_if and the design.
`timescale 1ns / 1ps

module keyframe_voxel_interpolator_top_test;

   localparam int CYCLE_LIMIT = 600000;
   localparam int ITEMS_PER_SETTING = 150;

   typedef struct packed {
      logic [15:0] scalar_a, na_x, na_y, na_z, scalar_b, nb_x, nb_y, nb_z;
      logic        last;
   } voxel_pair_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [kvi_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [kvi_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [kvi_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   kvi_req_if req_bus ();
   kvi_rsp_if rsp_bus ();

   keyframe_voxel_interpolator_top dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   voxel_pair_type            pending_voxels[$];
   kvi_pkg::rsp_type          expected_blends[$];
   logic [16:0]    shadow_fraction;
   logic [6:0]     shadow_key_count;
   int             mismatches;
   int             cycle_count;
   int             send_gap, stall_left;
   bit             bursty_send, bursty_recv;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x = x - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Lerp of two normal codes with 8 extra fraction bits, centered on midscale.
   function automatic longint centered_lerp(longint unsigned ea, longint unsigned eb,
                                            longint unsigned w);
      longint unsigned l;
      l = ea * (65536 - w) + eb * w;
      return longint'((l + 128) >> 8) - longint'(64'd32768 << 8);
   endfunction

   function automatic logic [15:0] encode_component(longint v, longint unsigned len);
      longint unsigned k, m, r;
      k = (v < 0) ? longint'(-v) : longint'(v);
      m = ((k << 23) + len) / (2 * len);
      if (v >= 0) begin
         r = 32768 + m;
         return (r > 65535) ? 16'hFFFF : r[15:0];
      end
      return (m >= 32768) ? 16'h0 : 16'(32768 - m);
   endfunction

   function automatic kvi_pkg::rsp_type blend_voxel(voxel_pair_type p);
      kvi_pkg::rsp_type r;
      longint unsigned cnt, top, lo, hi, w, t, s, len, len_sq;
      longint v[3];
      longint unsigned ea[3], eb[3];
      ea = '{p.na_x, p.na_y, p.na_z};
      eb = '{p.nb_x, p.nb_y, p.nb_z};
      cnt = shadow_key_count;
      if (cnt == 0) cnt = 1;
      if (cnt > kvi_pkg::MAX_KEYS) cnt = kvi_pkg::MAX_KEYS;
      top = cnt - 1;
      if (shadow_fraction == 0) begin
         lo = 0; hi = 0; w = 0;
      end else if (shadow_fraction >= 17'h10000) begin
         lo = top; hi = top; w = 0;
      end else begin
         t = longint'(shadow_fraction) * top;
         lo = t >> 16;
         w = t & 16'hFFFF;
         hi = (lo < top) ? lo + 1 : lo;
      end
      if (w == 0) begin
         r.blended_scalar = p.scalar_a;
         r.blended_normal_x = p.na_x;
         r.blended_normal_y = p.na_y;
         r.blended_normal_z = p.na_z;
      end else begin
         len_sq = (longint'(p.scalar_a) * (65536 - w) + longint'(p.scalar_b) * w + 32768) >> 16;
         r.blended_scalar = len_sq[15:0];
         s = 0;
         for (int i = 0; i < 3; i++) begin
            v[i] = centered_lerp(ea[i], eb[i], w);
            s = s + longint'(v[i] * v[i]);
         end
         if (s == 0) begin
            r.blended_normal_x = kvi_pkg::MID_CODE;
            r.blended_normal_y = kvi_pkg::MID_CODE;
            r.blended_normal_z = kvi_pkg::MID_CODE;
         end else begin
            len = int_sqrt(s << 14);
            r.blended_normal_x = encode_component(v[0], len);
            r.blended_normal_y = encode_component(v[1], len);
            r.blended_normal_z = encode_component(v[2], len);
         end
      end
      r.lower_key = lo[5:0];
      r.upper_key = hi[5:0];
      r.last_voxel_out = p.last;
      return r;
   endfunction

   // Codes are biased toward the rails and midscale so clipping and short normals occur.
   function automatic logic [15:0] pick_code();
      case ($urandom_range(0, 6))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000 + 16'($urandom_range(0, 8)) - 16'd4;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic voxel_pair_type random_pair();
      voxel_pair_type p;
      p.scalar_a = pick_code();
      p.na_x = pick_code();
      p.na_y = pick_code();
      p.na_z = pick_code();
      p.scalar_b = pick_code();
      p.nb_x = pick_code();
      p.nb_y = pick_code();
      p.nb_z = pick_code();
      p.last = ($urandom_range(0, 15) == 0);
      return p;
   endfunction

   function automatic voxel_pair_type make_pair(logic [15:0] sa, logic [15:0] na,
                                                logic [15:0] sb, logic [15:0] nb, logic last);
      voxel_pair_type p;
      p = '{sa, na, na, na, sb, nb, nb, nb, last};
      return p;
   endfunction

   // Appends one item to the tail of the send queue.
   function automatic void add_pending(voxel_pair_type p);
      pending_voxels = {pending_voxels, p};
   endfunction

   task automatic write_register(kvi_pkg::csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= kvi_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == kvi_pkg::REG_BLEND_FRACTION) shadow_fraction = value[16:0];
      else shadow_key_count = value[6:0];
   endtask

   // Sender: one item per handshake, with a drawn gap after each.
   always @(posedge clock) begin
      voxel_pair_type p;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.scalar_a <= '0;
         req_bus.normal_a_x <= '0;
         req_bus.normal_a_y <= '0;
         req_bus.normal_a_z <= '0;
         req_bus.scalar_b <= '0;
         req_bus.normal_b_x <= '0;
         req_bus.normal_b_y <= '0;
         req_bus.normal_b_z <= '0;
         req_bus.last_voxel_in <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            p = '{req_bus.scalar_a, req_bus.normal_a_x, req_bus.normal_a_y,
                  req_bus.normal_a_z, req_bus.scalar_b, req_bus.normal_b_x,
                  req_bus.normal_b_y, req_bus.normal_b_z, req_bus.last_voxel_in};
            expected_blends = {expected_blends, blend_voxel(p)};
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap != 0) begin
               req_bus.valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (pending_voxels.size() != 0) begin
               p = pending_voxels.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.scalar_a <= p.scalar_a;
               req_bus.normal_a_x <= p.na_x;
               req_bus.normal_a_y <= p.na_y;
               req_bus.normal_a_z <= p.na_z;
               req_bus.scalar_b <= p.scalar_b;
               req_bus.normal_b_x <= p.nb_x;
               req_bus.normal_b_y <= p.nb_y;
               req_bus.normal_b_z <= p.nb_z;
               req_bus.last_voxel_in <= p.last;
               send_gap <= bursty_send ? 0 : $urandom_range(0, 18);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each blended voxel and, unless bursty_recv is set, stalls for a drawn count after it.
   always @(posedge clock) begin
      kvi_pkg::rsp_type got, want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.blended_scalar, rsp_bus.blended_normal_x,
                    rsp_bus.blended_normal_y, rsp_bus.blended_normal_z,
                    rsp_bus.lower_key, rsp_bus.upper_key, rsp_bus.last_voxel_out};
            if (expected_blends.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected item: %p", got);
            end else begin
               want = expected_blends.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, actual %p", want, got);
               end
            end
         end
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_bus.valid && rsp_bus.ready && !bursty_recv)
               stall_left <= $urandom_range(0, 18);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** keyframe_voxel_interpolator_top: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [16:0] fractions[12];
      logic [6:0]  counts[12];
      fractions = '{17'h0, 17'h10000, 17'h5555, 17'h1FFFF, 17'h1, 17'hFFFF,
                    17'h8000, 17'h4000, 17'h3000, 17'h9999, 17'h0, 17'h0};
      counts = '{7'd1, 7'd64, 7'd64, 7'd7, 7'd64, 7'd64,
                 7'd2, 7'd5, 7'd0, 7'd127, 7'd1, 7'd1};
      fractions[10] = 17'($urandom_range(1, 65535));
      counts[10] = 7'($urandom_range(1, 64));
      fractions[11] = 17'($urandom_range(1, 65535));
      counts[11] = 7'($urandom_range(1, 127));
      bursty_send = 0;
      bursty_recv = 0;
      shadow_fraction = 0;
      shadow_key_count = 1;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 12; ph++) begin
         write_register(kvi_pkg::REG_BLEND_FRACTION, 32'(fractions[ph]));
         write_register(kvi_pkg::REG_KEY_COUNT, 32'(counts[ph]));
         bursty_send = ($urandom_range(0, 3) == 0);
         bursty_recv = ($urandom_range(0, 3) == 0);
         if (ph == 2) begin
            // Rails, equal and opposite normals, and the zero-length normal.
            add_pending(make_pair(16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 1'b0));
            add_pending(make_pair(16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 1'b1));
            add_pending(make_pair(16'h1234, 16'h8000, 16'h4321, 16'h8000, 1'b0));
            add_pending(make_pair(16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 1'b1));
            add_pending(make_pair(16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 1'b0));
            add_pending(make_pair(16'h8000, 16'h0, 16'h8000, 16'hFFFF, 1'b0));
            add_pending('{16'h5555, 16'hFFFF, 16'h8000, 16'h0,
                          16'hAAAA, 16'h0, 16'h8000, 16'hFFFF, 1'b1});
            add_pending('{16'h0, 16'h8001, 16'h7FFF, 16'h8000,
                          16'h1, 16'h8001, 16'h7FFF, 16'h8000, 1'b0});
         end
         for (int i = 0; i < ITEMS_PER_SETTING; i++) add_pending(random_pair());
         while (pending_voxels.size() != 0 || req_bus.valid || expected_blends.size() != 0)
            @(posedge clock);
         repeat (4) @(posedge clock);
      end
      repeat (80) @(posedge clock);
      if (mismatches == 0 && expected_blends.size() == 0)
         $display("** keyframe_voxel_interpolator_top: PASSED **");
      else
         $display("** keyframe_voxel_interpolator_top: FAILED **");
      $finish;
   end

endmodule
